// File: design/ertm_pkg.sv
// Shared constants and types for the extended Reinhard tone mapper.
// Used by ertm_front, ertm_div and the extended_reinhard_tonemap top level.
package ertm_pkg;

    localparam int IN_W         = 32;
    localparam int OUT_BITS     = 16;
    localparam int OUT_W        = OUT_BITS + 1;
    localparam int CH_N         = 3;
    localparam int FRONT_STAGES = 4;

    localparam logic [OUT_W-1:0]  OUT_ONE  = OUT_W'(1) << OUT_BITS;
    localparam logic [IN_W-1:0]   W_RESET  = IN_W'(65536);
    localparam logic [2*IN_W-1:0] W2_RESET = (2*IN_W)'(W_RESET) * (2*IN_W)'(W_RESET);

    typedef logic [IN_W-1:0]  chan_t;
    typedef logic [OUT_W-1:0] tone_t;

endpackage

// File: design/ertm_front.sv
// Front end of one channel: products, sums and the white-level compare.
// Produces the numerator, denominator and saturation flag for ertm_div; uses ertm_pkg.
module ertm_front #(
    parameter int FRAC_BITS = 16,
    parameter int DEN_W     = 97
) (
    input  logic                                clk,
    input  logic [ertm_pkg::FRONT_STAGES-1:0]   en,
    input  logic [ertm_pkg::IN_W-1:0]           white,
    input  logic [2*ertm_pkg::IN_W-1:0]         w2,
    input  logic [ertm_pkg::IN_W-1:0]           x_in,
    output logic [DEN_W-1:0]                    num,
    output logic [DEN_W-1:0]                    den,
    output logic                                sat
);
    import ertm_pkg::*;

    localparam int PW = 2 * IN_W;
    localparam int AW = 3 * IN_W;

    logic [IN_W-1:0]  x_reg;
    logic [PW-1:0]    plo_reg;
    logic [PW-1:0]    phi_reg;
    logic [PW-1:0]    sq_reg;
    logic [PW-1:0]    sq2_reg;
    logic [AW-1:0]    a_reg;
    logic [DEN_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic             sat1_reg;
    logic             sat2_reg;
    logic             sat3_reg;

    // The common term w^2 * x is shared by the numerator and the denominator.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg <= x_in;
        end
        if (en[1])
        begin
            plo_reg  <= PW'(w2[IN_W-1:0]) * PW'(x_reg);
            phi_reg  <= PW'(w2[PW-1:IN_W]) * PW'(x_reg);
            sq_reg   <= PW'(x_reg) * PW'(x_reg);
            sat1_reg <= (x_reg >= white);
        end
        if (en[2])
        begin
            a_reg    <= {phi_reg, {IN_W{1'b0}}} + AW'(plo_reg);
            sq2_reg  <= sq_reg;
            sat2_reg <= sat1_reg;
        end
        if (en[3])
        begin
            num_reg  <= sat2_reg ? '0 : DEN_W'(a_reg) + (DEN_W'(sq2_reg) << FRAC_BITS);
            den_reg  <= DEN_W'(a_reg) + (DEN_W'(w2) << FRAC_BITS);
            sat3_reg <= sat2_reg;
        end
    end

    assign num = num_reg;
    assign den = den_reg;
    assign sat = sat3_reg;

endmodule

// File: design/ertm_div.sv
// Pipelined restoring divider of one channel, one quotient bit per stage.
// Takes numerator and denominator from ertm_front; uses ertm_pkg.
module ertm_div #(
    parameter int DEN_W = 97
) (
    input  logic                            clk,
    input  logic [ertm_pkg::OUT_BITS-1:0]   en,
    input  logic [DEN_W-1:0]                num_in,
    input  logic [DEN_W-1:0]                den_in,
    input  logic                            sat_in,
    output logic [ertm_pkg::OUT_BITS-1:0]   quo,
    output logic                            sat
);
    import ertm_pkg::*;

    logic [DEN_W-1:0]    r_reg   [OUT_BITS-1];
    logic [DEN_W-1:0]    d_reg   [OUT_BITS-1];
    logic [OUT_BITS-1:0] q_reg   [OUT_BITS];
    logic [OUT_BITS-1:0] sat_reg;

    logic [DEN_W-1:0]    r_src   [OUT_BITS];
    logic [DEN_W-1:0]    d_src   [OUT_BITS];
    logic [OUT_BITS-1:0] q_src   [OUT_BITS];
    logic [OUT_BITS-1:0] s_src;
    logic [DEN_W:0]      t_w     [OUT_BITS];
    logic [DEN_W:0]      diff_w  [OUT_BITS];
    logic [OUT_BITS-1:0] ge;
    logic [DEN_W-1:0]    r_next  [OUT_BITS];

    always_comb
    begin
        r_src[0] = num_in;
        d_src[0] = den_in;
        q_src[0] = '0;
        s_src[0] = sat_in;
        for (int j = 1; j < OUT_BITS; j++)
        begin
            r_src[j] = r_reg[j-1];
            d_src[j] = d_reg[j-1];
            q_src[j] = q_reg[j-1];
            s_src[j] = sat_reg[j-1];
        end
        for (int j = 0; j < OUT_BITS; j++)
        begin
            t_w[j]    = {r_src[j], 1'b0};
            ge[j]     = (t_w[j] >= {1'b0, d_src[j]});
            diff_w[j] = t_w[j] - {1'b0, d_src[j]};
            r_next[j] = ge[j] ? diff_w[j][DEN_W-1:0] : t_w[j][DEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < OUT_BITS - 1; j++)
        begin
            if (en[j])
            begin
                r_reg[j] <= r_next[j];
                d_reg[j] <= d_src[j];
            end
        end
        for (int j = 0; j < OUT_BITS; j++)
        begin
            if (en[j])
            begin
                q_reg[j]   <= {q_src[j][OUT_BITS-2:0], ge[j]};
                sat_reg[j] <= s_src[j];
            end
        end
    end

    assign quo = q_reg[OUT_BITS-1];
    assign sat = sat_reg[OUT_BITS-1];

endmodule

// File: design/extended_reinhard_tonemap.sv
// Extended Reinhard tone mapper for a stream of RGB pixels, top level.
// Instantiates ertm_front and ertm_div per channel; uses ertm_pkg.
//
// The block maps each channel of an unsigned fixed-point HDR pixel through
// x(1 + x/w^2)/(1 + x) and returns Q1.16 results rounded toward zero, with
// channels at or above the white level saturated to exactly 1.0. It takes one
// word per clock while the pipeline has room; each word passes through four
// stages of multiplies and adds, sixteen stages of the restoring divider that
// produce one quotient bit each, and the output register. The pipeline closes
// bubbles during a stall, so input words are still taken while a result waits.
// The user must write the white level through the configuration port only
// while the block is idle; the block does not enforce this. A value of zero
// acts as one, and a pixel may follow in the cycle after the write.
module extended_reinhard_tonemap #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ertm_pkg::IN_W-1:0]     white_level,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ertm_pkg::IN_W-1:0]     red_in,
    input  logic [ertm_pkg::IN_W-1:0]     green_in,
    input  logic [ertm_pkg::IN_W-1:0]     blue_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ertm_pkg::OUT_W-1:0]    red_out,
    output logic [ertm_pkg::OUT_W-1:0]    green_out,
    output logic [ertm_pkg::OUT_W-1:0]    blue_out
);
    import ertm_pkg::*;

    localparam int DEN_W = 2 * IN_W + ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 1;
    localparam int NSTG  = FRONT_STAGES + OUT_BITS + 1;

    logic [IN_W-1:0]     white_reg;
    logic [2*IN_W-1:0]   w2_reg;
    logic [NSTG-1:0]     v_reg;
    logic [NSTG-1:0]     v_src;
    logic [NSTG-1:0]     en;

    chan_t               chan_in  [CH_N];
    logic [DEN_W-1:0]    num_w    [CH_N];
    logic [DEN_W-1:0]    den_w    [CH_N];
    logic [CH_N-1:0]     fsat_w;
    logic [OUT_BITS-1:0] quo_w    [CH_N];
    logic [CH_N-1:0]     dsat_w;
    tone_t               out_reg  [CH_N];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_reg <= W_RESET;
            w2_reg    <= W2_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                white_reg <= (white_level == '0) ? IN_W'(1) : white_level;
            end
            w2_reg <= {{IN_W{1'b0}}, white_reg} * {{IN_W{1'b0}}, white_reg};
        end
    end

    // A stage may load when it or some stage after it is empty, or the output is taken.
    for (genvar k = 0; k < NSTG; k++)
    begin : g_en
        assign en[k] = out_ready || !(&v_reg[NSTG-1:k]);
    end

    assign v_src = {v_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_src[k];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    assign chan_in[0] = red_in;
    assign chan_in[1] = green_in;
    assign chan_in[2] = blue_in;

    for (genvar c = 0; c < CH_N; c++)
    begin : g_chan
        ertm_front #(
            .FRAC_BITS (FRAC_BITS),
            .DEN_W     (DEN_W)
        ) u_front (
            .clk   (clk),
            .en    (en[FRONT_STAGES-1:0]),
            .white (white_reg),
            .w2    (w2_reg),
            .x_in  (chan_in[c]),
            .num   (num_w[c]),
            .den   (den_w[c]),
            .sat   (fsat_w[c])
        );

        ertm_div #(
            .DEN_W (DEN_W)
        ) u_div (
            .clk    (clk),
            .en     (en[FRONT_STAGES+OUT_BITS-1:FRONT_STAGES]),
            .num_in (num_w[c]),
            .den_in (den_w[c]),
            .sat_in (fsat_w[c]),
            .quo    (quo_w[c]),
            .sat    (dsat_w[c])
        );

        always_ff @(posedge clk)
        begin
            if (en[NSTG-1])
            begin
                out_reg[c] <= dsat_w[c] ? OUT_ONE : {1'b0, quo_w[c]};
            end
        end
    end

    assign red_out   = out_reg[0];
    assign green_out = out_reg[1];
    assign blue_out  = out_reg[2];

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_out <= OUT_ONE) && (green_out <= OUT_ONE) && (blue_out <= OUT_ONE))
        else $error("tone-mapped word exceeds 1.0");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&v_reg) && !out_ready)
        else $error("input refused while the pipeline has room");

    a_white_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> white_reg != '0)
        else $error("white level register holds zero");

endmodule

// File: test/extended_reinhard_tonemap_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for extended_reinhard_tonemap: random and directed pixels,
// several white levels, random idling on both sides. Depends on ertm_pkg and the DUT.
module extended_reinhard_tonemap_tb;
    import ertm_pkg::*;

    localparam int FRAC = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_PER_PHASE = 175;
    localparam int PHASE_N = 8;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    typedef struct packed {
        tone_t red;
        tone_t green;
        tone_t blue;
    } rgb_tone_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    chan_t white_level = '0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    chan_t red_in = '0;
    chan_t green_in = '0;
    chan_t blue_in = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    tone_t red_out;
    tone_t green_out;
    tone_t blue_out;

    pixel_t    pending_pixels[$];
    rgb_tone_t expected_tones[$];
    chan_t     active_white = W_RESET;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;

    extended_reinhard_tonemap #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .white_level(white_level),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic tone_t tone_channel(chan_t x, chan_t w);
        logic [63:0]  w_sq;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quot;
        if (w == '0)
            w = chan_t'(1);
        if (x >= w)
            return OUT_ONE;
        w_sq = 64'(w) * 64'(w);
        num  = (128'(w_sq) + (128'(x) << FRAC)) * (128'(x) << OUT_BITS);
        den  = 128'(w_sq) * ((128'(1) << FRAC) + 128'(x));
        quot = num / den;
        if (quot > 128'(OUT_ONE))
            quot = 128'(OUT_ONE);
        return tone_t'(quot);
    endfunction

    function automatic chan_t pick_channel(chan_t w);
        chan_t wl;
        wl = (w == '0) ? chan_t'(1) : w;
        case ($urandom_range(9))
            0: return '0;
            1, 2, 3: return $urandom_range(wl - 1, 0);
            4: return (wl > 16) ? wl - 1 - $urandom_range(15) : $urandom_range(wl - 1, 0);
            5: return wl + $urandom_range(15);
            6: return $urandom_range(32'h0003_FFFF);
            default: return $urandom();
        endcase
    endfunction

    // Driver: holds a word until it is taken and predicts its result on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t    next_pixel;
        rgb_tone_t prediction;
        logic      taken;
        logic      load;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            taken = in_valid && in_ready;
            if (taken)
            begin
                prediction.red   = tone_channel(red_in, active_white);
                prediction.green = tone_channel(green_in, active_white);
                prediction.blue  = tone_channel(blue_in, active_white);
                expected_tones.push_back(prediction);
            end
            if (in_valid && !taken)
                load = 1'b0;
            else
                load = (pending_pixels.size() > 0) && ($urandom_range(99) >= send_idle_pct);
            if (load)
            begin
                next_pixel = pending_pixels.pop_front();
                in_valid <= 1'b1;
                red_in   <= next_pixel.red;
                green_in <= next_pixel.green;
                blue_in  <= next_pixel.blue;
            end
            else if (taken)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        rgb_tone_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tones.size() == 0)
                begin
                    $display("%0t: unexpected word, got %0d %0d %0d", $realtime,
                             red_out, green_out, blue_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_tones.pop_front();
                    if (red_out !== want.red)
                    begin
                        $display("%0t: red expected %0d, got %0d", $realtime, want.red, red_out);
                        mismatch_count++;
                    end
                    if (green_out !== want.green)
                    begin
                        $display("%0t: green expected %0d, got %0d", $realtime, want.green,
                                 green_out);
                        mismatch_count++;
                    end
                    if (blue_out !== want.blue)
                    begin
                        $display("%0t: blue expected %0d, got %0d", $realtime, want.blue,
                                 blue_out);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_pixel(input chan_t r, input chan_t g, input chan_t b);
        pixel_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        pending_pixels.push_back(p);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || in_valid || expected_tones.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_white(input chan_t value);
        cfg_valid   <= 1'b1;
        white_level <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        active_white <= value;
        cfg_valid    <= 1'b0;
    endtask

    initial
    begin
        chan_t white_table[PHASE_N];
        chan_t w;
        white_table[0] = 32'h0001_0000;
        white_table[1] = 32'h0000_0000;
        white_table[2] = 32'h0000_0001;
        white_table[3] = 32'hFFFF_FFFF;
        white_table[4] = $urandom();
        white_table[5] = 32'h0000_8000;
        white_table[6] = $urandom_range(32'h0100_0000, 32'h0001_0000);
        white_table[7] = $urandom_range(32'h0000_FFFF, 32'h0000_0002);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_pixel(32'h0, 32'h0, 32'h0);
        add_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_pixel(32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001);
        add_pixel(32'h0000_0001, 32'h0000_8000, 32'h0000_0002);
        add_pixel(32'h8000_0000, 32'h0000_4000, 32'h0000_C000);
        add_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFE);
        wait_drained();

        for (int p = 0; p < PHASE_N; p++)
        begin
            write_white(white_table[p]);
            send_idle_pct  = (p % 4 == 1) ? 45 : (p % 4 == 3) ? 7 : 0;
            recv_stall_pct = (p % 4 == 2) ? 45 : (p % 4 == 3) ? 7 : 0;
            w = white_table[p];
            if (w == 32'h0)
            begin
                add_pixel(32'h0, 32'h1, 32'hFFFF_FFFF);
                add_pixel(32'h2, 32'h0, 32'h8000_0000);
            end
            if (w == 32'hFFFF_FFFF)
            begin
                add_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0);
                add_pixel(32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_0000);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                add_pixel(pick_channel(w), pick_channel(w), pick_channel(w));
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
